FILE: rtl/core/hlfk_pkg.sv
package hlfk_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int HALF_Q    = ONE_Q / 2;
  // saturation and luminosity thresholds (0.01 and 0.02 of one)
  localparam int TH_LO     = (ONE_Q + 50) / 100;
  localparam int TH_HI     = (2 * ONE_Q + 50) / 100;
  localparam int LUM_MAX   = 9 * (1 << (FRAC_BITS - 3)) + (1 << (FRAC_BITS - 3)) - 1;

  localparam logic [16:0] SQRT3_Q16 = 17'd113512;
  // floor(2^28 / 41); (x >> 4) / 41 gives x / 656 = x / (TH_HI - TH_LO)
  localparam logic [22:0] RECIP_41  = 23'd6547206;
  localparam int          LOG_STEPS = FRAC_BITS - 3;

  typedef enum logic [2:0] {
    CFG_HUE_LO      = 3'd0,
    CFG_HUE_HI      = 3'd1,
    CFG_HUE_FEATHER = 3'd2,
    CFG_LUMA_LO     = 3'd3,
    CFG_LUMA_HI     = 3'd4,
    CFG_LUMA_FEATHER= 3'd5,
    CFG_LUMA_WEIGHTS= 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TRAP_ZERO,
    TRAP_ONE,
    TRAP_LOW,
    TRAP_HIGH
  } trap_code_t;

  typedef struct packed {
    trap_code_t  code;
    logic [31:0] num;
    logic [15:0] den;
  } trap_sel_t;

  typedef struct packed {
    trap_code_t hcode;
    trap_code_t lcode;
    logic       active;
    logic       sramp;
    logic       lramp;
    logic [9:0] sdelta;
    logic [9:0] ldelta;
  } side_t;

endpackage

FILE: rtl/core/hlfk_div.sv
module hlfk_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QB = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  // restoring division, one quotient bit per stage; needs (num >> QB) < den
  logic [DW-1:0] rem_r [QB];
  logic [QB-1:0] low_r [QB];
  logic [DW-1:0] den_r [QB];
  logic [QB-1:0] quo_r [QB];
  logic [NW-1:0] top_bits;

  assign top_bits = num >> QB;

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QB-1:0] low_in;
    logic [QB-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in = top_bits[DW-1:0];
      assign low_in = num[QB-1:0];
      assign q_in   = '0;
      assign d_in   = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = quo_r[k-1];
      assign d_in   = den_r[k-1];
    end

    assign trial   = {rem_in, low_in[QB-1]};
    assign diff    = trial - {1'b0, d_in};
    assign ge      = trial >= {1'b0, d_in};
    assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= low_in << 1;
        den_r[k] <= d_in;
        quo_r[k] <= {q_in[QB-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule

FILE: rtl/core/hue_luma_feathered_key_mask_core.sv
// The pipeline holds 46 register stages.
// Throughput: one item per clock while out_tready does not hold the pipe; depth is set by the bit-per-stage dividers
// (saturation, hue, two feather ramps) and the 13 squaring steps of the log unit.
// Reset (rst_n low, synchronous) clears the stage valid bits and loads the
// configuration defaults; pipeline data registers are not reset.
module hue_luma_feathered_key_mask_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // red_sample, green_sample, blue_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // mask_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import hlfk_pkg::*;

  localparam int LAST = 46;

  // configuration
  logic [18:0] hue_lo_r, hue_hi_r;
  logic [31:0] hue_feather_r, luma_feather_r;
  logic [17:0] luma_lo_r, luma_hi_r;
  logic [47:0] luma_weights_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_lo_r       <= '0;
      hue_hi_r       <= 19'(ONE_Q);
      hue_feather_r  <= '0;
      luma_lo_r      <= 18'(-ONE_Q);
      luma_hi_r      <= 18'(ONE_Q);
      luma_feather_r <= '0;
      luma_weights_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HUE_LO:       hue_lo_r       <= cfg_data[18:0];
        CFG_HUE_HI:       hue_hi_r       <= cfg_data[18:0];
        CFG_HUE_FEATHER:  hue_feather_r  <= cfg_data[31:0];
        CFG_LUMA_LO:      luma_lo_r      <= cfg_data[17:0];
        CFG_LUMA_HI:      luma_hi_r      <= cfg_data[17:0];
        CFG_LUMA_FEATHER: luma_feather_r <= cfg_data[31:0];
        CFG_LUMA_WEIGHTS: luma_weights_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // bounds in a common 21-bit signed domain; hue wrap derived from the bounds
  localparam logic signed [20:0] ONE_W  = 21'(ONE_Q);
  localparam logic signed [20:0] HALF_W = 21'(HALF_Q);

  logic signed [20:0] hlo_s, hhi_s, hlf_s, hhf_s, llo_s, lhi_s;
  logic signed [20:0] hlo_w, hhi_w, hue_edge;
  logic [15:0]        hlf, hhf, llf, lhf;
  logic               wrap_pos, wrap_neg;

  always_comb begin
    hlf   = hue_feather_r[15:0];
    hhf   = hue_feather_r[31:16];
    llf   = luma_feather_r[15:0];
    lhf   = luma_feather_r[31:16];
    hlo_s = signed'({{2{hue_lo_r[18]}}, hue_lo_r});
    hhi_s = signed'({{2{hue_hi_r[18]}}, hue_hi_r});
    llo_s = signed'({{3{luma_lo_r[17]}}, luma_lo_r});
    lhi_s = signed'({{3{luma_hi_r[17]}}, luma_hi_r});
    hlf_s = signed'({5'b0, hlf});
    hhf_s = signed'({5'b0, hhf});
    wrap_pos = (hlo_s < 21'sd0) || ((hlo_s - hlf_s) < 21'sd0) || (hhi_s < 21'sd0);
    wrap_neg = (hlo_s > ONE_W) || ((hhi_s + hhf_s) > ONE_W) || (hhi_s > ONE_W);
    hlo_w    = wrap_pos ? hlo_s + ONE_W : hlo_s;
    hhi_w    = wrap_pos ? hhi_s + ONE_W : hhi_s;
    hue_edge = hlo_w - hlf_s;
  end

  function automatic trap_sel_t trap_select(input logic signed [20:0] v,
                                            input logic signed [20:0] lo,
                                            input logic signed [20:0] hi,
                                            input logic [15:0] lf,
                                            input logic [15:0] hf);
    logic signed [20:0] lo_edge, hi_edge, dl, dh;
    trap_sel_t s;
    lo_edge = lo - signed'({5'b0, lf});
    hi_edge = hi + signed'({5'b0, hf});
    dl      = v - lo_edge;
    dh      = hi_edge - v;
    s.code  = TRAP_ZERO;
    s.num   = {dl[15:0], 16'h0};
    s.den   = lf;
    if (v >= lo && v <= hi) begin
      s.code = TRAP_ONE;
    end else if (v >= lo_edge && v < lo) begin
      s.code = TRAP_LOW;
    end else if (v > hi && v <= hi_edge) begin
      s.code = TRAP_HIGH;
      s.num  = {dh[15:0], 16'h0};
      s.den  = hf;
    end
    return s;
  endfunction

  function automatic logic [16:0] div656_fix(input logic [21:0] x, input logic [44:0] y);
    logic [16:0] q0;
    logic [22:0] r;
    q0 = y[44:28];
    r  = {1'b0, x} - 23'(q0) * 23'd41;
    return (r >= 23'd41) ? q0 + 17'd1 : q0;
  endfunction

  function automatic logic [5:0] top_bit(input logic [33:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < 34; i++) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  // flow control: the whole pipe advances together; stage 1 also fills when empty
  logic [LAST:1] vld_r;
  logic          en, ld1;

  assign en        = !vld_r[LAST] || out_tready;
  assign ld1       = en || !vld_r[1];
  assign in_tready = ld1;
  assign out_tvalid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld1) vld_r[1] <= in_tvalid;
      if (en) vld_r[LAST:2] <= vld_r[LAST-1:1];
    end
  end

  // stage 1: input item
  logic [15:0] s1_red_r, s1_green_r, s1_blue_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_red_r   <= in_tdata[15:0];
      s1_green_r <= in_tdata[31:16];
      s1_blue_r  <= in_tdata[47:32];
    end
  end

  // stage 2: max/min, luma products, hue terms
  logic [15:0]        cmax, cmin, dgb;
  logic signed [17:0] x2_nxt;
  logic [32:0]        a_nxt;

  always_comb begin
    cmax = (s1_red_r > s1_green_r) ? s1_red_r : s1_green_r;
    if (s1_blue_r > cmax) cmax = s1_blue_r;
    cmin = (s1_red_r < s1_green_r) ? s1_red_r : s1_green_r;
    if (s1_blue_r < cmin) cmin = s1_blue_r;
    dgb    = (s1_green_r >= s1_blue_r) ? s1_green_r - s1_blue_r : s1_blue_r - s1_green_r;
    x2_nxt = signed'({1'b0, s1_red_r, 1'b0}) - signed'({2'b0, s1_green_r})
             - signed'({2'b0, s1_blue_r});
    a_nxt  = 33'(dgb) * 33'(SQRT3_Q16) + 33'd1;
  end

  logic [31:0]        s2_pr_r, s2_pg_r, s2_pb_r, s2_sat_num_r;
  logic [32:0]        s2_a_r;
  logic signed [17:0] s2_x2_r;
  logic [15:0]        s2_sat_den_r;
  logic [19:2]        bg_r;

  // stage 3: luma sum, hue divider operands
  logic [17:0] x2_neg;
  logic [16:0] ax;
  logic [32:0] pterm;
  logic [34:0] hn_sum;
  logic [33:0] hd_sum;

  always_comb begin
    x2_neg = 18'(-s2_x2_r);
    ax     = s2_x2_r[17] ? x2_neg[16:0] : s2_x2_r[16:0];
    pterm  = {ax, 16'h0};
    hn_sum = 35'(s2_a_r) + (s2_x2_r[17] ? {1'b0, pterm, 1'b0} : 35'd0);
    hd_sum = 34'(s2_a_r) + 34'(pterm);
  end

  logic [33:0] s3_sum_r;
  logic [50:0] s3_hnum_r;
  logic [35:0] s3_hden_r;

  // stage 4/5: leading one, normalize
  logic [33:0] s4_sum_r;
  logic [5:0]  s4_e_r;
  logic        s4_lt_r;
  logic [33:0] norm;
  logic [30:0] s5_m_r;
  logic [5:0]  s5_e_r;
  logic        s5_lt_r;

  assign norm = s4_sum_r << 6'(6'd33 - s4_e_r);

  // stages 6..18: log2 fraction by repeated squaring
  logic [30:0]          sq_m_r    [LOG_STEPS];
  logic [LOG_STEPS-1:0] sq_frac_r [LOG_STEPS];
  logic [5:0]           sq_e_r    [LOG_STEPS];
  logic                 sq_lt_r   [LOG_STEPS];

  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_sq
    logic [30:0]          m_in;
    logic [LOG_STEPS-1:0] f_in;
    logic [5:0]           e_in;
    logic                 lt_in;
    logic [61:0]          prod;
    logic [31:0]          t;

    if (k == 0) begin : g_first
      assign m_in  = s5_m_r;
      assign f_in  = '0;
      assign e_in  = s5_e_r;
      assign lt_in = s5_lt_r;
    end else begin : g_next
      assign m_in  = sq_m_r[k-1];
      assign f_in  = sq_frac_r[k-1];
      assign e_in  = sq_e_r[k-1];
      assign lt_in = sq_lt_r[k-1];
    end

    assign prod = 62'(m_in) * 62'(m_in);
    assign t    = prod[61:30];

    always_ff @(posedge clk) begin
      if (en) begin
        sq_m_r[k]    <= t[31] ? t[31:1] : t[30:0];
        sq_frac_r[k] <= {f_in[LOG_STEPS-2:0], t[31]};
        sq_e_r[k]    <= e_in;
        sq_lt_r[k]   <= lt_in;
      end
    end
  end

  // stage 19: luminosity; dividers deliver saturation and hue here
  logic [5:0]         em;
  logic signed [17:0] s19_lum_r;
  logic [16:0]        sat_q;
  logic [15:0]        hue_q;

  assign em = sq_e_r[LOG_STEPS-1] - 6'd24;

  hlfk_div #(.NW(32), .DW(16), .QB(17)) u_sat_div (
    .clk (clk),
    .en  (en),
    .num (s2_sat_num_r),
    .den (s2_sat_den_r),
    .quo (sat_q)
  );

  hlfk_div #(.NW(51), .DW(36), .QB(16)) u_hue_div (
    .clk (clk),
    .en  (en),
    .num (s3_hnum_r),
    .den (s3_hden_r),
    .quo (hue_q)
  );

  // stage 20: hue fold and wrap
  logic [16:0]        h0;
  logic signed [20:0] h0s;
  logic               hadd;

  always_comb begin
    h0   = (bg_r[19] && hue_q != 16'd0) ? 17'(ONE_Q) - {1'b0, hue_q} : {1'b0, hue_q};
    h0s  = signed'({4'b0, h0});
    hadd = wrap_pos ? (h0s < hue_edge) : (wrap_neg && h0s < HALF_W);
  end

  logic signed [20:0] s20_h_r;
  logic [16:0]        s20_sat_r;
  logic signed [17:0] s20_lum_r;

  // stage 21: window branch selection
  trap_sel_t htr, ltr;
  side_t     side_nxt;

  always_comb begin
    htr = trap_select(s20_h_r, hlo_w, hhi_w, hlf, hhf);
    ltr = trap_select(signed'({{3{s20_lum_r[17]}}, s20_lum_r}), llo_s, lhi_s, llf, lhf);
    side_nxt.hcode  = htr.code;
    side_nxt.lcode  = ltr.code;
    side_nxt.active = (s20_sat_r > 17'(TH_LO)) && (s20_lum_r > 18'sd655);
    side_nxt.sramp  = s20_sat_r < 17'(TH_HI);
    side_nxt.lramp  = s20_lum_r < 18'sd1311;
    side_nxt.sdelta = 10'(s20_sat_r - 17'(TH_LO));
    side_nxt.ldelta = 10'(s20_lum_r - 18'(TH_LO));
  end

  logic [31:0] s21_hnum_r, s21_lnum_r;
  logic [15:0] s21_hden_r, s21_lden_r;
  side_t       side_r [21:37];
  logic [15:0] hue_tq, luma_tq;

  hlfk_div #(.NW(32), .DW(16), .QB(16)) u_hue_trap_div (
    .clk (clk),
    .en  (en),
    .num (s21_hnum_r),
    .den (s21_hden_r),
    .quo (hue_tq)
  );

  hlfk_div #(.NW(32), .DW(16), .QB(16)) u_luma_trap_div (
    .clk (clk),
    .en  (en),
    .num (s21_lnum_r),
    .den (s21_lden_r),
    .quo (luma_tq)
  );

  // stage 38: window values
  logic [16:0] cm_nxt, lm_nxt;

  always_comb begin
    case (side_r[37].hcode)
      TRAP_ONE:             cm_nxt = 17'(ONE_Q);
      TRAP_LOW, TRAP_HIGH:  cm_nxt = {1'b0, hue_tq};
      default:              cm_nxt = '0;
    endcase
    if (!side_r[37].active) cm_nxt = '0;
    case (side_r[37].lcode)
      TRAP_ONE:             lm_nxt = 17'(ONE_Q);
      TRAP_LOW, TRAP_HIGH:  lm_nxt = {1'b0, luma_tq};
      default:              lm_nxt = '0;
    endcase
  end

  logic [16:0] s38_cm_r, s38_lm_r, s39_cm_r, s39_lm_r, s40_cm_r, s40_lm_r;
  logic [16:0] s41_cm_r, s41_lm_r, s42_cm_r, s42_lm_r, s43_cm_r, s43_lm_r;
  logic [16:0] s44_cm_r, s44_lm_r, s45_m_r;
  side_t       s38_side_r, s39_side_r, s40_side_r, s41_side_r, s42_side_r, s43_side_r;
  logic [26:0] s39_p_r, s42_p_r;
  logic [21:0] s40_x_r, s43_x_r;
  logic [44:0] s40_y_r, s43_y_r;
  logic [33:0] mprod;
  logic [24:0] kprod;
  logic [7:0]  s46_mask_r;

  assign mprod = 34'(s44_cm_r) * 34'(s44_lm_r);
  assign kprod = 25'(s45_m_r) * 25'd255;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 2
      s2_pr_r      <= 32'(luma_weights_r[15:0]) * 32'(s1_red_r);
      s2_pg_r      <= 32'(luma_weights_r[31:16]) * 32'(s1_green_r);
      s2_pb_r      <= 32'(luma_weights_r[47:32]) * 32'(s1_blue_r);
      s2_a_r       <= a_nxt;
      s2_x2_r      <= x2_nxt;
      s2_sat_num_r <= {cmax - cmin, 16'h0};
      s2_sat_den_r <= (cmax == 16'd0) ? 16'd1 : cmax;
      bg_r         <= {bg_r[18:2], s1_blue_r > s1_green_r};
      // stage 3
      s3_sum_r  <= 34'(s2_pr_r) + 34'(s2_pg_r) + 34'(s2_pb_r);
      s3_hnum_r <= {hn_sum, 16'h0};
      s3_hden_r <= {hd_sum, 2'b00};
      // stage 4
      s4_sum_r <= s3_sum_r;
      s4_e_r   <= top_bit(s3_sum_r);
      s4_lt_r  <= s3_sum_r[33:16] == 18'd0;
      // stage 5
      s5_m_r  <= norm[33:3];
      s5_e_r  <= s4_e_r;
      s5_lt_r <= s4_lt_r;
      // stage 19
      s19_lum_r <= sq_lt_r[LOG_STEPS-1] ? 18'(-ONE_Q)
                                        : signed'({em[4:0], sq_frac_r[LOG_STEPS-1]});
      // stage 20
      s20_h_r   <= hadd ? h0s + ONE_W : h0s;
      s20_sat_r <= sat_q;
      s20_lum_r <= s19_lum_r;
      // stage 21
      s21_hnum_r <= htr.num;
      s21_hden_r <= htr.den;
      s21_lnum_r <= ltr.num;
      s21_lden_r <= ltr.den;
      side_r[21] <= side_nxt;
      for (int k = 22; k <= 37; k++) side_r[k] <= side_r[k-1];
      // stage 38
      s38_cm_r   <= cm_nxt;
      s38_lm_r   <= lm_nxt;
      s38_side_r <= side_r[37];
      // stages 39..41: saturation ramp, divide by 656
      s39_p_r    <= 27'(s38_cm_r) * 27'(s38_side_r.sdelta);
      s39_cm_r   <= s38_cm_r;
      s39_lm_r   <= s38_lm_r;
      s39_side_r <= s38_side_r;
      s40_x_r    <= s39_p_r[25:4];
      s40_y_r    <= 45'(s39_p_r[25:4]) * 45'(RECIP_41);
      s40_cm_r   <= s39_cm_r;
      s40_lm_r   <= s39_lm_r;
      s40_side_r <= s39_side_r;
      s41_cm_r   <= s40_side_r.sramp ? div656_fix(s40_x_r, s40_y_r) : s40_cm_r;
      s41_lm_r   <= s40_lm_r;
      s41_side_r <= s40_side_r;
      // stages 42..44: luminosity ramp
      s42_p_r    <= 27'(s41_cm_r) * 27'(s41_side_r.ldelta);
      s42_cm_r   <= s41_cm_r;
      s42_lm_r   <= s41_lm_r;
      s42_side_r <= s41_side_r;
      s43_x_r    <= s42_p_r[25:4];
      s43_y_r    <= 45'(s42_p_r[25:4]) * 45'(RECIP_41);
      s43_cm_r   <= s42_cm_r;
      s43_lm_r   <= s42_lm_r;
      s43_side_r <= s42_side_r;
      s44_cm_r   <= s43_side_r.lramp ? div656_fix(s43_x_r, s43_y_r) : s43_cm_r;
      s44_lm_r   <= s43_lm_r;
      // stage 45/46: combine and scale to 8 bits
      s45_m_r    <= mprod[32:16];
      s46_mask_r <= kprod[23:16];
    end
  end

  assign out_tdata = s46_mask_r;

  a_fill_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[LAST] |-> in_tready)
    else $error("input held off with an empty output stage");

  a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[18] && !sq_lt_r[LOG_STEPS-1] |-> sq_m_r[LOG_STEPS-1][30])
    else $error("log mantissa lost normalization");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[19] |-> sat_q <= 17'(ONE_Q))
    else $error("saturation above one");

  a_lum_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[19] |-> (s19_lum_r >= 18'(-ONE_Q)) && (int'(s19_lum_r) <= LUM_MAX))
    else $error("luminosity out of range");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[20] |-> (s20_h_r >= 21'sd0) && (s20_h_r <= ONE_W + ONE_W))
    else $error("wrapped hue out of range");

endmodule
